### design/sefr_pkg.sv
// Package: shared types and constants for the STX/ETX frame receiver.
package sefr_pkg;

	localparam logic [7:0] START_BYTE = 8'h02;
	localparam logic [7:0] END_BYTE   = 8'h03;

	localparam logic [1:0] ST_GOOD    = 2'd0;
	localparam logic [1:0] ST_BAD_END = 2'd1;
	localparam logic [1:0] ST_BAD_BCC = 2'd2;

	typedef enum logic [2:0] {
		PH_HUNT    = 3'd0,
		PH_HEADER  = 3'd1,
		PH_PAYLOAD = 3'd2,
		PH_ENDB    = 3'd3,
		PH_CHECK   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       is_header;
		logic       frame_end;
		logic [1:0] status;
	} res_t;

endpackage

### design/sefr_byte_if.sv
// Interface: received byte channel with valid/ready handshake.
interface sefr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

### design/sefr_result_if.sv
// Interface: frame result channel with valid/ready handshake.
interface sefr_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	logic       is_header;
	logic       frame_end;
	logic [1:0] status;

	modport source (output valid, output data, output is_header, output frame_end,
		output status, input ready);
	modport sink (input valid, input data, input is_header, input frame_end,
		input status, output ready);
endinterface

### design/stx_etx_xor_frame_receiver.sv
// Top level: STX/ETX frame receiver with XOR block check.
//
//   channel  modport  payload                               beat
//   rx       sink     rx_byte[7:0]                          one received byte
//   result   source   data, is_header, frame_end, status    one result
//
// One byte per cycle unless the result channel stalls.
// Path: input register, parser state machine, output register.
// Reset clears both valid flags and the parser state to hunting.
// A stalled result holds the output register; the input register then fills and rx.ready drops.
module stx_etx_xor_frame_receiver
	import sefr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	sefr_byte_if.sink     rx,
	sefr_result_if.source result
);

	logic       out_free;
	logic       step;
	logic [7:0] byte_s1;
	logic       res_valid;
	res_t       res;

	sefr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.out_free (out_free),
		.step     (step),
		.byte_s1  (byte_s1)
	);

	sefr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.byte_s1   (byte_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	sefr_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (step && res_valid),
		.res      (res),
		.out_free (out_free),
		.result   (result)
	);

endmodule

### design/sefr_in_stage.sv
// Input register stage: holds one received byte until the parser consumes it.
module sefr_in_stage (
	input  logic         clk,
	input  logic         arst_n,
	sefr_byte_if.sink    rx,
	input  logic         out_free,
	output logic         step,
	output logic [7:0]   byte_s1
);

	logic valid_s1;

	assign step     = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

### design/sefr_parser.sv
// Frame parser: phase state machine, length count and XOR block check.
module sefr_parser
	import sefr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] byte_s1,
	output logic       res_valid,
	output res_t       res
);

	phase_t      phase_q, phase_d;
	logic [1:0]  header_count_q, header_count_d;
	logic [7:0]  length_high_q, length_high_d;
	logic [15:0] payload_left_q, payload_left_d;
	logic [7:0]  running_xor_q, running_xor_d;
	logic        end_byte_ok_q, end_byte_ok_d;
	logic [15:0] length_full;

	assign length_full = {length_high_q, byte_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			header_count_q <= 2'd0;
			length_high_q  <= 8'd0;
			payload_left_q <= 16'd0;
			running_xor_q  <= 8'd0;
			end_byte_ok_q  <= 1'b0;
		end else if (step) begin
			phase_q        <= phase_d;
			header_count_q <= header_count_d;
			length_high_q  <= length_high_d;
			payload_left_q <= payload_left_d;
			running_xor_q  <= running_xor_d;
			end_byte_ok_q  <= end_byte_ok_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		header_count_d = header_count_q;
		length_high_d  = length_high_q;
		payload_left_d = payload_left_q;
		running_xor_d  = running_xor_q;
		end_byte_ok_d  = end_byte_ok_q;
		res_valid      = 1'b0;
		res.data       = byte_s1;
		res.is_header  = 1'b0;
		res.frame_end  = 1'b0;
		res.status     = ST_GOOD;
		unique case (phase_q)
			PH_HEADER: begin
				res_valid     = 1'b1;
				res.is_header = 1'b1;
				running_xor_d = running_xor_q ^ byte_s1;
				if (header_count_q == 2'd2) begin
					length_high_d = byte_s1;
				end
				if (header_count_q == 2'd3) begin
					payload_left_d = length_full;
					header_count_d = 2'd0;
					phase_d        = (length_full == 16'd0) ? PH_ENDB : PH_PAYLOAD;
				end else begin
					header_count_d = header_count_q + 2'd1;
				end
			end
			PH_PAYLOAD: begin
				res_valid      = 1'b1;
				running_xor_d  = running_xor_q ^ byte_s1;
				payload_left_d = payload_left_q - 16'd1;
				if (payload_left_q == 16'd1) begin
					phase_d = PH_ENDB;
				end
			end
			PH_ENDB: begin
				end_byte_ok_d = (byte_s1 == END_BYTE);
				phase_d       = PH_CHECK;
			end
			PH_CHECK: begin
				res_valid     = 1'b1;
				res.frame_end = 1'b1;
				if (!end_byte_ok_q) begin
					res.status = ST_BAD_END;
				end else if (byte_s1 != running_xor_q) begin
					res.status = ST_BAD_BCC;
				end else begin
					res.status = ST_GOOD;
				end
				phase_d        = PH_HUNT;
				header_count_d = 2'd0;
				length_high_d  = 8'd0;
				payload_left_d = 16'd0;
				running_xor_d  = 8'd0;
				end_byte_ok_d  = 1'b0;
			end
			default: begin
				// hunting, and any unused phase code
				header_count_d = 2'd0;
				length_high_d  = 8'd0;
				payload_left_d = 16'd0;
				running_xor_d  = 8'd0;
				end_byte_ok_d  = 1'b0;
				phase_d        = (byte_s1 == START_BYTE) ? PH_HEADER : PH_HUNT;
			end
		endcase
	end

	a_end_not_header: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.frame_end |-> !res.is_header)
		else $error("frame end flagged as header byte");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.frame_end |-> res.status == ST_GOOD)
		else $error("nonzero status outside frame end");

	a_check_returns_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_CHECK |=> phase_q == PH_HUNT && running_xor_q == 8'd0)
		else $error("check byte did not return to hunting");

	a_payload_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == PH_PAYLOAD && payload_left_q == 16'd1 |=> phase_q == PH_ENDB)
		else $error("last payload byte did not move to end byte");

endmodule

### design/sefr_out_stage.sv
// Output register stage: holds one result beat until the sink takes it.
module sefr_out_stage
	import sefr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  res_t          res,
	output logic          out_free,
	sefr_result_if.source result
);

	logic valid_q;
	res_t res_q;

	assign out_free         = !valid_q || result.ready;
	assign result.valid     = valid_q;
	assign result.data      = res_q.data;
	assign result.is_header = res_q.is_header;
	assign result.frame_end = res_q.frame_end;
	assign result.status    = res_q.status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && load) begin
			res_q <= res;
		end
	end

endmodule

### tb/sv/tb_stx_etx_xor_frame_receiver.sv
// Testbench for the STX/ETX frame receiver: random framed byte stream, predicted results checked.
`timescale 1ns / 100ps

module tb_stx_etx_xor_frame_receiver;
	import sefr_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int RANDOM_BEATS = 750;

	typedef struct {
		logic [7:0] b;
		bit         hold;
	} rx_beat_t;

	logic clk;
	logic arst_n;

	sefr_byte_if   rx();
	sefr_result_if res();

	stx_etx_xor_frame_receiver uut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.result (res)
	);

	rx_beat_t rx_stream[$];
	res_t     frame_results_due[$];
	bit       results_drained = 1'b1;
	int       n_sent = 0;
	int       third;
	int       n_errors = 0;
	int       quiet_cycles = 0;

	// parser copy
	phase_t      ph = PH_HUNT;
	logic [1:0]  hdr_cnt = 2'd0;
	logic [7:0]  len_hi = 8'd0;
	logic [15:0] left = 16'd0;
	logic [7:0]  bcc = 8'd0;
	logic        end_ok = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int cur_mode();
		if (n_sent < third)
			return 0;
		if (n_sent < 2 * third)
			return 1;
		return 2;
	endfunction

	function automatic int idle_pct(input bit sender, input int m);
		case (m)
			0: return sender ? 7 : 72;
			1: return sender ? 72 : 7;
			default: return 0;
		endcase
	endfunction

	function automatic void clear_parser();
		ph = PH_HUNT;
		hdr_cnt = 2'd0;
		len_hi = 8'd0;
		left = 16'd0;
		bcc = 8'd0;
		end_ok = 1'b0;
	endfunction

	function automatic void queue_result(input res_t r);
		frame_results_due.insert(frame_results_due.size(), r);
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		logic [1:0] st;
		case (ph)
			PH_HEADER: begin
				bcc = bcc ^ b;
				if (hdr_cnt == 2'd2)
					len_hi = b;
				if (hdr_cnt == 2'd3) begin
					left = {len_hi, b};
					hdr_cnt = 2'd0;
					ph = (left == 16'd0) ? PH_ENDB : PH_PAYLOAD;
				end else begin
					hdr_cnt = hdr_cnt + 2'd1;
				end
				queue_result('{data: b, is_header: 1'b1, frame_end: 1'b0,
					status: ST_GOOD});
			end
			PH_PAYLOAD: begin
				bcc = bcc ^ b;
				left = left - 16'd1;
				if (left == 16'd0)
					ph = PH_ENDB;
				queue_result('{data: b, is_header: 1'b0, frame_end: 1'b0,
					status: ST_GOOD});
			end
			PH_ENDB: begin
				end_ok = (b == END_BYTE);
				ph = PH_CHECK;
			end
			PH_CHECK: begin
				if (!end_ok)
					st = ST_BAD_END;
				else if (b != bcc)
					st = ST_BAD_BCC;
				else
					st = ST_GOOD;
				queue_result('{data: b, is_header: 1'b0, frame_end: 1'b1,
					status: st});
				clear_parser();
			end
			default: begin
				if (b == START_BYTE) begin
					clear_parser();
					ph = PH_HEADER;
				end else begin
					ph = PH_HUNT;
				end
			end
		endcase
	endfunction

	function automatic void push_beat(input logic [7:0] b, input bit hold = 1'b0);
		rx_stream.insert(rx_stream.size(), '{b: b, hold: hold});
	endfunction

	function automatic void add_frame(input logic [7:0] h0, input logic [7:0] h1,
		input logic [15:0] len, input bit rand_fill, input logic [7:0] fill,
		input bit bad_end, input bit bad_bcc, input bit hold);
		logic [7:0] x;
		logic [7:0] p;
		logic [7:0] e;
		x = h0 ^ h1 ^ len[15:8] ^ len[7:0];
		push_beat(START_BYTE, hold);
		push_beat(h0);
		push_beat(h1);
		push_beat(len[15:8]);
		push_beat(len[7:0]);
		for (int i = 0; i < len; i++) begin
			p = rand_fill ? 8'($urandom) : fill;
			x = x ^ p;
			push_beat(p);
		end
		e = END_BYTE;
		if (bad_end) begin
			e = 8'($urandom);
			if (e == END_BYTE)
				e = 8'hFC;
		end
		push_beat(e);
		push_beat(bad_bcc ? x ^ 8'($urandom_range(1, 255)) : x);
	endfunction

	function automatic logic [7:0] noise_byte();
		logic [7:0] n;
		n = 8'($urandom);
		if (n == START_BYTE)
			n = 8'hFD;
		return n;
	endfunction

	function automatic logic [15:0] pick_len();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return 16'($urandom_range(128, 300));
		if (r < 15)
			return 16'($urandom_range(13, 40));
		return 16'($urandom_range(0, 12));
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
			rx.rx_byte <= 8'd0;
		end else if (!rx.valid || rx.ready) begin
			if (rx_stream.size() != 0 && $urandom_range(99) >= idle_pct(1'b1, cur_mode())
				&& !(rx_stream[0].hold && (!results_drained || rx.valid))) begin
				rx.valid <= 1'b1;
				rx.rx_byte <= rx_stream[0].b;
				rx_stream.pop_front();
				n_sent <= n_sent + 1;
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// result sink backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res.ready <= 1'b0;
		else
			res.ready <= ($urandom_range(99) >= idle_pct(1'b0, cur_mode()));
	end

	// monitor: predict on accepted rx beat, check accepted result beat
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (rx.valid && rx.ready)
				parse_byte(rx.rx_byte);
			if (res.valid && res.ready) begin
				got = '{data: res.data, is_header: res.is_header, frame_end: res.frame_end,
					status: res.status};
				if (frame_results_due.size() == 0) begin
					$display("%0t: unexpected result beat data=%h hdr=%b end=%b st=%0d",
						$time, got.data, got.is_header, got.frame_end, got.status);
					n_errors++;
				end else begin
					want = frame_results_due.pop_front();
					if (got.data !== want.data || got.is_header !== want.is_header
						|| got.frame_end !== want.frame_end || got.status !== want.status) begin
						$display("%0t: exp d=%h h=%b e=%b s=%0d got d=%h h=%b e=%b s=%0d",
							$time, want.data, want.is_header, want.frame_end, want.status,
							got.data, got.is_header, got.frame_end, got.status);
						n_errors++;
					end
				end
			end
			results_drained <= (frame_results_due.size() == 0);
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx.valid && rx.ready) || (res.valid && res.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("FAIL stx_etx_xor_frame_receiver");
				$finish;
			end
		end
	end

	initial begin
		int r;
		arst_n = 1'b0;
		third = 0;

		// directed: noise while hunting, extreme headers, STX inside frame, error cases
		push_beat(8'h00);
		push_beat(8'hFF);
		add_frame(8'h00, 8'hFF, 16'd0, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0);
		add_frame(8'hFF, 8'h00, 16'd1, 1'b0, START_BYTE, 1'b1, 1'b1, 1'b0);
		push_beat(END_BYTE);
		add_frame(8'hA5, 8'h5A, 16'd0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1);

		add_frame(8'($urandom), 8'($urandom), pick_len(), 1'b1, 8'h00, 1'b0, 1'b0, 1'b1);
		while (rx_stream.size() < RANDOM_BEATS - 25) begin
			r = $urandom_range(99);
			if (r < 10)
				push_beat(noise_byte());
			else
				add_frame(8'($urandom), 8'($urandom), pick_len(), 1'b1, 8'h00,
					$urandom_range(99) < 10, $urandom_range(99) < 10,
					$urandom_range(99) < 3);
		end
		// maximum declared length, left unfinished
		push_beat(START_BYTE, 1'b1);
		push_beat(8'($urandom));
		push_beat(8'($urandom));
		push_beat(8'hFF);
		push_beat(8'hFF);
		for (int i = 0; i < 20; i++)
			push_beat(8'($urandom));
		third = rx_stream.size() / 3;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (rx_stream.size() != 0 || rx.valid || !results_drained);
		repeat (10) @(posedge clk);

		if (n_errors == 0 && frame_results_due.size() == 0) begin
			$display("PASS stx_etx_xor_frame_receiver");
		end else begin
			if (frame_results_due.size() != 0)
				$display("%0t: %0d expected results never arrived", $time,
					frame_results_due.size());
			$display("FAIL stx_etx_xor_frame_receiver");
		end
		$finish;
	end

endmodule

### sim.f
design/sefr_pkg.sv
design/sefr_byte_if.sv
design/sefr_result_if.sv
design/sefr_in_stage.sv
design/sefr_parser.sv
design/sefr_out_stage.sv
design/stx_etx_xor_frame_receiver.sv
tb/sv/tb_stx_etx_xor_frame_receiver.sv
